[hw/rtl/kclpd_pkg.sv]
// Package for the key click / long-press detector.
// Holds the key count, widths, register map and reset values; no dependencies.
`default_nettype none

package kclpd_pkg;

  localparam int KEY_COUNT = 8;   // keys in use, 1 to 8
  localparam int KEY_W     = 8;   // width of the key level and flag fields
  localparam int TICK_W    = 8;   // width of the hold counter and threshold

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((2 ** KEY_COUNT) - 1);

  // APB register map: one 32-bit register at byte address 0
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_LONG_PRESS_TICKS = 1'b0;   // register index, paddr[2]

  localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RESET = TICK_W'(100);

endpackage

`default_nettype wire

[hw/rtl/key_click_long_press_detector.sv]
// Key click / long-press detector, top level.
// Depends on kclpd_pkg for widths, key mask and the register map.
`default_nettype none

// One transfer on the input channel is one scan tick: the sampled key levels
// and the click flags that software has consumed since the last tick. Each
// tick yields exactly one result: the sticky click flags and the long-press
// flags after that tick. A key pressed and released before long_press_ticks
// ticks have gone by sets its click flag, which stays set until acknowledged
// through click_ack. A key held for long_press_ticks ticks sets its long-press
// flag, which clears as soon as the key is released. A new press during an
// unfinished run turns the keys still pending into clicks if the hold count
// is below long_press_ticks. The detector takes one tick per clock cycle: the
// update is a single pass of mask logic and an 8-bit counter compare between
// the state registers and the result register, and a new tick is taken
// whenever the result register is empty or its result is being transferred
// in the same cycle. long_press_ticks sits at byte address 0 of the APB port
// (reset 100, a value of 0 means 256 ticks); the user must see that it is
// written only while the detector is idle, as the block does not enforce it.
module key_click_long_press_detector (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // scan tick input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [kclpd_pkg::KEY_W-1:0]         key_levels,
  input  wire logic [kclpd_pkg::KEY_W-1:0]         click_ack,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [kclpd_pkg::KEY_W-1:0]              click_flags,
  output logic [kclpd_pkg::KEY_W-1:0]              long_flags,
  // APB configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [kclpd_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [kclpd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kclpd_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                     pready
);

  // configuration
  logic [kclpd_pkg::TICK_W-1:0] long_press_ticks;

  // detector state
  logic [kclpd_pkg::KEY_W-1:0]  previous_levels, previous_levels_next;
  logic [kclpd_pkg::KEY_W-1:0]  pending_keys,    pending_keys_next;
  logic [kclpd_pkg::TICK_W-1:0] hold_count,      hold_count_next;
  logic [kclpd_pkg::KEY_W-1:0]  click_store,     click_store_next;
  logic [kclpd_pkg::KEY_W-1:0]  long_store,      long_store_next;

  // intermediate values of the tick update
  logic [kclpd_pkg::KEY_W-1:0]  levels, ack, rising, released;
  logic [kclpd_pkg::KEY_W-1:0]  click_acked, click_forced, click_rel;
  logic [kclpd_pkg::KEY_W-1:0]  pend_start, pend_timed, pend_rel;
  logic [kclpd_pkg::TICK_W-1:0] hold_start, hold_inc, hold_timed;
  logic [kclpd_pkg::KEY_W-1:0]  long_timed;
  logic                         in_xfer;

  // ---------------------------------------------------------------------
  // APB port: pready tied high, single register
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= kclpd_pkg::LONG_PRESS_TICKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == kclpd_pkg::REG_LONG_PRESS_TICKS) begin
      long_press_ticks <= pwdata[kclpd_pkg::TICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kclpd_pkg::REG_LONG_PRESS_TICKS) begin
      prdata = kclpd_pkg::APB_DATA_W'(long_press_ticks);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: take a tick whenever the result register frees up
  // ---------------------------------------------------------------------
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Tick update, one pass
  // ---------------------------------------------------------------------
  always_comb begin
    levels = key_levels & kclpd_pkg::KEY_MASK;
    ack    = click_ack  & kclpd_pkg::KEY_MASK;

    // drop acknowledged clicks first
    click_acked = click_store & ~ack;
    rising      = levels & ~previous_levels;

    // new press: restart the run, unfinished pending keys become clicks
    click_forced = click_acked;
    pend_start   = pending_keys;
    hold_start   = hold_count;
    if (rising != '0) begin
      if (pending_keys != '0 && hold_count < long_press_ticks) begin
        click_forced = click_acked | pending_keys;
      end
      pend_start = rising;
      hold_start = '0;
    end

    // advance the hold counter; at threshold pending keys turn long
    hold_inc   = hold_start + kclpd_pkg::TICK_W'(1);
    hold_timed = hold_start;
    pend_timed = pend_start;
    long_timed = long_store;
    if (pend_start != '0) begin
      hold_timed = hold_inc;
      if (hold_inc == long_press_ticks) begin
        long_timed = pend_start;
        pend_timed = '0;
        hold_timed = '0;
      end
    end

    // release of a pending key marks a click and trims the run
    released  = pend_timed & ~levels;
    click_rel = click_forced;
    pend_rel  = pend_timed;
    hold_count_next = hold_timed;
    if (pend_start != '0 && released != '0) begin
      click_rel = click_forced | released;
      pend_rel  = pend_timed & ~click_rel;
      if (pend_rel == '0) begin
        hold_count_next = '0;
      end
    end

    click_store_next     = click_rel;
    pending_keys_next    = pend_rel;
    long_store_next      = long_timed & levels;
    previous_levels_next = levels;
  end

  // hold state; update only on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
      pending_keys    <= '0;
      hold_count      <= '0;
      click_store     <= '0;
      long_store      <= '0;
    end else if (in_xfer) begin
      previous_levels <= previous_levels_next;
      pending_keys    <= pending_keys_next;
      hold_count      <= hold_count_next;
      click_store     <= click_store_next;
      long_store      <= long_store_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      click_flags <= click_store_next & kclpd_pkg::KEY_MASK;
      long_flags  <= long_store_next  & kclpd_pkg::KEY_MASK;
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the key click / long-press detector.
// Needs kclpd_pkg and key_click_long_press_detector; reads no files.
`timescale 1ns / 100ps

module testbench;
  import kclpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [APB_ADDR_W-1:0] TICKS_ADDR = APB_ADDR_W'(4 * int'(REG_LONG_PRESS_TICKS));

  typedef struct packed {
    logic [KEY_W-1:0] levels;
    logic [KEY_W-1:0] ack;
  } scan_tick_t;

  typedef struct packed {
    logic [KEY_W-1:0] clicks;
    logic [KEY_W-1:0] longs;
  } flag_pair_t;

  // DUT connections; every input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KEY_W-1:0] key_levels = '0;
  logic [KEY_W-1:0] click_ack = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] click_flags;
  logic [KEY_W-1:0] long_flags;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Detector state mirrored by the predictor
  logic [TICK_W-1:0] thresh = LONG_PRESS_TICKS_RESET;
  logic [KEY_W-1:0] prev_lvl = '0;
  logic [KEY_W-1:0] pend_mask = '0;
  logic [TICK_W-1:0] hold_cnt = '0;
  logic [KEY_W-1:0] click_sticky = '0;
  logic [KEY_W-1:0] long_held = '0;

  scan_tick_t tick_queue[$];      // scan ticks waiting to be offered
  flag_pair_t flag_expect_q[$];   // predicted flags, oldest first
  logic [KEY_W-1:0] gen_levels = '0;  // last key levels queued by the generator
  int mismatch_count = 0;
  int cycle_count = 0;

  // Driver-private
  scan_tick_t next_tick;
  int burst_left = 0;
  int gap_left = 0;

  // Monitor-private
  flag_pair_t want_flags;
  int rx_cycle = 0;
  int hold_off_left = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;

  key_click_long_press_detector uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_levels (key_levels),
    .click_ack  (click_ack),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .click_flags(click_flags),
    .long_flags (long_flags),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mirrored detector by one scan tick and return the flags it shows.
  // Clear acknowledged clicks first, then handle a new press, then count the
  // run, then handle releases, and finally drop long presses of released keys.
  function automatic flag_pair_t scan_tick_update(input logic [KEY_W-1:0] lvl_in,
                                                  input logic [KEY_W-1:0] ack_in);
    logic [KEY_W-1:0] lvl;
    logic [KEY_W-1:0] ack;
    logic [KEY_W-1:0] rising;
    logic [KEY_W-1:0] released;
    flag_pair_t res;
    lvl = lvl_in & KEY_MASK;
    ack = ack_in & KEY_MASK;
    click_sticky = click_sticky & ~ack & KEY_MASK;
    rising = lvl & ~prev_lvl;
    if (rising != '0) begin
      // a fresh press turns an unfinished run into clicks; with a zero
      // threshold the compare never holds, so nothing is forced
      if (pend_mask != '0 && hold_cnt < thresh) click_sticky = click_sticky | pend_mask;
      pend_mask = rising;
      hold_cnt = '0;
    end
    if (pend_mask != '0) begin
      hold_cnt = hold_cnt + 1'b1;   // 8-bit, wraps at 256
      if (hold_cnt == thresh) begin
        long_held = pend_mask;      // replaces earlier long presses
        pend_mask = '0;
        hold_cnt = '0;
      end
      released = pend_mask & ~lvl;
      if (released != '0) begin
        click_sticky = click_sticky | released;
        // pending keys with an unacknowledged click leave the run too
        pend_mask = pend_mask & ~click_sticky;
        if (pend_mask == '0) hold_cnt = '0;
      end
    end
    long_held = long_held & lvl;
    prev_lvl = lvl;
    res.clicks = click_sticky & KEY_MASK;
    res.longs = long_held & KEY_MASK;
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_ack();
    case ($urandom_range(0, 5))
      3:       return KEY_W'($urandom_range(0, 255));
      4:       return '1;
      default: return '0;
    endcase
  endfunction

  task automatic queue_tick(input logic [KEY_W-1:0] levels, input logic [KEY_W-1:0] ack);
    scan_tick_t t;
    t.levels = levels;
    t.ack = ack;
    tick_queue.push_back(t);
    gen_levels = levels;
  endtask

  // Queue press/hold/release episodes sized around the current threshold so
  // that runs end just before, at and just after the long-press point. Mix in
  // overlapping presses and short bursts of noise.
  task automatic add_run(input int budget);
    logic [KEY_W-1:0] fresh;
    logic [KEY_W-1:0] held;
    int span_base;
    int span;
    int kind;
    span_base = (thresh == '0) ? 256 : int'(thresh);
    while (budget > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        fresh = $urandom_range(0, 1) ? KEY_W'(1) << $urandom_range(0, KEY_W - 1)
                                     : KEY_W'($urandom_range(1, 255));
        held = (kind < 3) ? (gen_levels | fresh) : fresh;
        case ($urandom_range(0, 4))
          0:       span = span_base - 1;
          1:       span = span_base;
          2:       span = span_base + 1;
          default: span = $urandom_range(1, span_base + 3);
        endcase
        if (span < 1) span = 1;
        for (int i = 0; i < span; i++) queue_tick(held, pick_ack());
        // release some or all keys
        queue_tick($urandom_range(0, 1) ? '0 : (held & KEY_W'($urandom_range(0, 255))),
                   pick_ack());
        budget -= span + 1;
      end else begin
        span = $urandom_range(1, 6);
        for (int i = 0; i < span; i++)
          queue_tick(KEY_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 255)));
        budget -= span;
      end
    end
  endtask

  // Wait until every queued tick is transferred and every result has come back.
  task automatic settle();
    while (tick_queue.size() != 0 || in_valid || flag_expect_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write of the threshold: setup cycle, then access until pready.
  task automatic write_ticks(input logic [TICK_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TICKS_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh = value;
  endtask

  // Sender: offer queued ticks in bursts of random length with random gaps.
  // Predict at the transfer, so the expectation order follows the input order.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      key_levels <= '0;
      click_ack <= '0;
    end else begin
      if (in_valid && in_ready) flag_expect_q.push_back(scan_tick_update(key_levels, click_ack));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          key_levels <= next_tick.levels;
          click_ack <= next_tick.ack;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
              0, 1:    gap_left = 0;
              5:       gap_left = $urandom_range(7, 15);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest prediction, and stall on
  // a pattern that cycles through four modes as rx_cycle grows. Hold off once
  // for a long stretch so the detector fills up and pushes back on the sender.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) begin
        results_seen++;
        if (flag_expect_q.size() == 0) begin
          $error("result with no tick outstanding: click_flags %h long_flags %h",
                 click_flags, long_flags);
          mismatch_count++;
        end else begin
          want_flags = flag_expect_q.pop_front();
          if (click_flags !== want_flags.clicks) begin
            $error("click_flags: expected %h, got %h", want_flags.clicks, click_flags);
            mismatch_count++;
          end
          if (long_flags !== want_flags.longs) begin
            $error("long_flags: expected %h, got %h", want_flags.longs, long_flags);
            mismatch_count++;
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        hold_off_left = 300;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 499) == 0) begin
        hold_off_left = $urandom_range(40, 120);
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (rx_cycle % 5) == 0;
          default: out_ready <= (rx_cycle % 7) >= 3;
        endcase
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes at the reset threshold
    queue_tick('0, '0);
    queue_tick('1, '1);
    queue_tick('0, '0);
    settle();

    // Directed: short threshold for click, long press and the corner cases
    write_ticks(TICK_W'(3));
    queue_tick('0, '1);
    queue_tick(8'h01, '0);          // press and release: click
    queue_tick(8'h00, '0);
    queue_tick(8'h03, '0);          // release while key 0 still has a click
    queue_tick(8'h01, '0);
    queue_tick(8'h00, '1);
    repeat (3) queue_tick(8'h02, '0);  // held to the threshold: long press
    queue_tick(8'h06, '0);
    queue_tick(8'h0E, '0);          // fresh press forces the pending key to click
    queue_tick(8'h06, '0);
    queue_tick(8'h00, '1);
    repeat (3) queue_tick(8'h10, '0);
    repeat (3) queue_tick(8'h30, '0);  // second long press replaces the first
    queue_tick(8'h00, '0);
    settle();

    // Random episodes across thresholds, extremes included
    write_ticks(TICK_W'(1));
    add_run(150);
    settle();
    write_ticks(TICK_W'(2));
    add_run(150);
    settle();
    write_ticks(TICK_W'(7));
    add_run(150);
    settle();
    write_ticks(LONG_PRESS_TICKS_RESET);
    add_run(250);
    settle();

    // Leave a run open past the next threshold, then lower it: the counter
    // must wrap before it matches
    write_ticks(TICK_W'(20));
    add_run(150);
    queue_tick('0, '0);
    repeat (15) queue_tick(8'h80, '0);
    settle();
    write_ticks(TICK_W'(5));
    repeat (260) queue_tick(8'h80, pick_ack());
    add_run(100);
    settle();

    write_ticks(TICK_W'(255));
    add_run(150);
    settle();
    write_ticks(TICK_W'(0));        // zero means a 256-tick long press
    add_run(150);
    settle();

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && flag_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
